/* hdl/mau_pkg.sv */
// Shared types and constants for the modular arithmetic unit.
// Used by mau_ctrl, mau_datapath and modular_arithmetic_unit.
`timescale 1ns / 1ps
`default_nettype none
package mau_pkg;

   localparam int DVD_W = 64;
   localparam int CNT_W = 7;
   localparam logic [30:0] RESET_MODULUS = 31'd998244353;

   localparam logic [3:0] ACT_ADD = 4'd0;
   localparam logic [3:0] ACT_SUB = 4'd1;
   localparam logic [3:0] ACT_MUL = 4'd2;
   localparam logic [3:0] ACT_DIV = 4'd3;
   localparam logic [3:0] ACT_NEG = 4'd4;
   localparam logic [3:0] ACT_POW = 4'd5;
   localparam logic [3:0] ACT_INV = 4'd6;
   localparam logic [3:0] ACT_RED = 4'd7;
   localparam logic [3:0] ACT_CMP = 4'd8;

   typedef struct packed {
      logic [3:0]         action;
      logic [30:0]        operand_a;
      logic [30:0]        operand_b;
      logic [63:0]        exponent;
      logic signed [63:0] raw_value;
   } req_type;

   typedef struct packed {
      logic [30:0] result;
      logic        valid_res;
      logic        equal;
   } rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_RED_A, ST_WAIT_A, ST_RED_B, ST_WAIT_B, ST_DISPATCH,
      ST_DIV_MUL, ST_WAIT_MUL, ST_WAIT_RAW,
      ST_POW_CHECK, ST_POW_DIV_PB, ST_WAIT_PB, ST_POW_MUL_BB, ST_POW_DIV_BB, ST_WAIT_BB,
      ST_EUC_CHECK, ST_EUC_WAIT, ST_EUC_STEP, ST_EUC_END, ST_INV_MUL, ST_OUT
   } state_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_LOAD, OP_DIV_A, OP_DIV_B, OP_DIV_PROD, OP_DIV_RAW, OP_DIV_EUC,
      OP_SET_A, OP_SET_B, OP_MUL_AB, OP_MUL_PB, OP_MUL_BB, OP_MUL_TP, OP_MUL_IA,
      OP_SET_SIMPLE, OP_SET_RES_REM, OP_SET_RES_RAW, OP_SET_RES_P, OP_SET_P,
      OP_SET_BASE, OP_POW_INIT, OP_EUC_INIT, OP_EUC_STEP, OP_SET_FAIL,
      OP_SET_INV, OP_SET_INV_RES
   } op_type;

   typedef struct packed {
      op_type op;
   } ctl_type;

   typedef struct packed {
      logic [3:0] action;
      logic       div_busy;
      logic       e_zero;
      logic       e_lsb;
      logic       ea_zero;
      logic       emm_one;
   } sts_type;

endpackage
`default_nettype wire

/* hdl/mau_datapath.sv */
// Datapath: operand, modulus and Euclid registers, shared multiplier and
// bit-serial restoring divider. Depends on mau_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mau_datapath #(
   parameter int MOD_WIDTH = 31
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_valid,
   input  wire logic [30:0]      csr_data,
   input  wire mau_pkg::req_type req_data,
   input  wire mau_pkg::ctl_type ctl,
   output mau_pkg::sts_type      sts,
   output mau_pkg::rsp_type      rsp_data
);
   localparam int W = MOD_WIDTH;

   logic [W-1:0] modulus_ff;
   logic [W-1:0] m_ff;
   logic [3:0]   act_ff;
   logic [W-1:0] a_ff, b_ff, p_ff, base_ff, inv_ff, ea_ff, emm_ff;
   logic [63:0]  e_ff;
   logic [63:0]  raw_ff;
   logic signed [W:0] ep_ff, eq_ff;
   logic signed [2*W+1:0] prod_ff;
   logic signed [W:0] mul_x, mul_y;

   logic [mau_pkg::DVD_W-1:0] dvd_ff;
   logic [W:0]   rem_ff;
   logic [W-1:0] quo_ff, dsr_ff;
   logic [mau_pkg::CNT_W-1:0] cnt_ff;
   logic         busy_ff;

   logic [W-1:0] res_ff;
   logic         valid_ff, equal_ff;

   logic [W:0]   shl, add_s, sub_s;
   logic         ge;
   logic [W-1:0] simple_res;
   logic         simple_valid;
   logic signed [W:0] qnorm, mext;
   logic [63:0]  raw_mag;
   logic [W-1:0] rem_w;

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= mau_pkg::RESET_MODULUS[W-1:0];
      end else if (csr_valid) begin
         modulus_ff <= csr_data[W-1:0];
      end
   end

   assign rem_w = rem_ff[W-1:0];
   assign shl   = {rem_ff[W-1:0], dvd_ff[mau_pkg::DVD_W-1]};
   assign ge    = shl >= {1'b0, dsr_ff};
   assign raw_mag = raw_ff[63] ? (~raw_ff + 64'd1) : raw_ff;
   assign mext  = $signed({1'b0, m_ff});

   always_comb begin
      qnorm = eq_ff;
      if (eq_ff < 0) begin
         qnorm = eq_ff + mext;
      end else if (eq_ff >= mext) begin
         qnorm = eq_ff - mext;
      end
   end

   always_comb begin
      add_s = {1'b0, a_ff} + {1'b0, b_ff};
      if (add_s >= {1'b0, m_ff}) begin
         add_s = add_s - {1'b0, m_ff};
      end
      if (a_ff >= b_ff) begin
         sub_s = {1'b0, a_ff} - {1'b0, b_ff};
      end else begin
         sub_s = {1'b0, a_ff} + {1'b0, m_ff} - {1'b0, b_ff};
      end
      simple_valid = 1'b1;
      case (act_ff)
         mau_pkg::ACT_ADD: simple_res = add_s[W-1:0];
         mau_pkg::ACT_SUB: simple_res = sub_s[W-1:0];
         mau_pkg::ACT_NEG: simple_res = (a_ff != '0) ? m_ff - a_ff : '0;
         mau_pkg::ACT_CMP: simple_res = '0;
         default: begin
            simple_res   = '0;
            simple_valid = 1'b0;
         end
      endcase
   end

   always_comb begin
      mul_x = $signed({1'b0, a_ff});
      mul_y = $signed({1'b0, b_ff});
      case (ctl.op)
         mau_pkg::OP_MUL_PB: begin
            mul_x = $signed({1'b0, p_ff});
            mul_y = $signed({1'b0, base_ff});
         end
         mau_pkg::OP_MUL_BB: begin
            mul_x = $signed({1'b0, base_ff});
            mul_y = $signed({1'b0, base_ff});
         end
         mau_pkg::OP_MUL_TP: begin
            mul_x = $signed({1'b0, quo_ff});
            mul_y = ep_ff;
         end
         mau_pkg::OP_MUL_IA: begin
            mul_x = $signed({1'b0, inv_ff});
            mul_y = $signed({1'b0, a_ff});
         end
         default: ;
      endcase
   end

   // divider
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (ctl.op == mau_pkg::OP_DIV_A || ctl.op == mau_pkg::OP_DIV_B ||
                   ctl.op == mau_pkg::OP_DIV_PROD || ctl.op == mau_pkg::OP_DIV_RAW ||
                   ctl.op == mau_pkg::OP_DIV_EUC) begin
         busy_ff <= 1'b1;
      end else if (busy_ff && cnt_ff == mau_pkg::CNT_W'(1)) begin
         busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      case (ctl.op)
         mau_pkg::OP_DIV_A, mau_pkg::OP_DIV_B, mau_pkg::OP_DIV_PROD,
         mau_pkg::OP_DIV_RAW, mau_pkg::OP_DIV_EUC: begin
            rem_ff <= '0;
            quo_ff <= '0;
            case (ctl.op)
               mau_pkg::OP_DIV_A: begin
                  dvd_ff <= {a_ff, {(mau_pkg::DVD_W-W){1'b0}}};
                  dsr_ff <= m_ff;
                  cnt_ff <= mau_pkg::CNT_W'(W);
               end
               mau_pkg::OP_DIV_B: begin
                  dvd_ff <= {b_ff, {(mau_pkg::DVD_W-W){1'b0}}};
                  dsr_ff <= m_ff;
                  cnt_ff <= mau_pkg::CNT_W'(W);
               end
               mau_pkg::OP_DIV_PROD: begin
                  dvd_ff <= {prod_ff[2*W-1:0], {(mau_pkg::DVD_W-2*W){1'b0}}};
                  dsr_ff <= m_ff;
                  cnt_ff <= mau_pkg::CNT_W'(2*W);
               end
               mau_pkg::OP_DIV_RAW: begin
                  dvd_ff <= raw_mag;
                  dsr_ff <= m_ff;
                  cnt_ff <= mau_pkg::CNT_W'(mau_pkg::DVD_W);
               end
               default: begin
                  dvd_ff <= {emm_ff, {(mau_pkg::DVD_W-W){1'b0}}};
                  dsr_ff <= ea_ff;
                  cnt_ff <= mau_pkg::CNT_W'(W);
               end
            endcase
         end
         default: begin
            if (busy_ff) begin
               rem_ff <= ge ? shl - {1'b0, dsr_ff} : shl;
               quo_ff <= {quo_ff[W-2:0], ge};
               dvd_ff <= {dvd_ff[mau_pkg::DVD_W-2:0], 1'b0};
               cnt_ff <= cnt_ff - mau_pkg::CNT_W'(1);
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      case (ctl.op)
         mau_pkg::OP_LOAD: begin
            act_ff <= req_data.action;
            a_ff   <= req_data.operand_a[W-1:0];
            b_ff   <= req_data.operand_b[W-1:0];
            e_ff   <= req_data.exponent;
            raw_ff <= req_data.raw_value;
            m_ff   <= (modulus_ff == '0) ? W'(1) : modulus_ff;
         end
         mau_pkg::OP_SET_A: a_ff <= rem_w;
         mau_pkg::OP_SET_B: b_ff <= rem_w;
         mau_pkg::OP_MUL_AB, mau_pkg::OP_MUL_PB, mau_pkg::OP_MUL_BB,
         mau_pkg::OP_MUL_TP, mau_pkg::OP_MUL_IA: prod_ff <= mul_x * mul_y;
         mau_pkg::OP_POW_INIT: begin
            p_ff    <= (m_ff == W'(1)) ? '0 : W'(1);
            base_ff <= a_ff;
         end
         mau_pkg::OP_SET_P: p_ff <= rem_w;
         mau_pkg::OP_SET_BASE: begin
            base_ff <= rem_w;
            e_ff    <= {1'b0, e_ff[63:1]};
         end
         mau_pkg::OP_EUC_INIT: begin
            ea_ff  <= (act_ff == mau_pkg::ACT_DIV) ? b_ff : a_ff;
            emm_ff <= m_ff;
            ep_ff  <= (W+1)'(1);
            eq_ff  <= '0;
         end
         mau_pkg::OP_EUC_STEP: begin
            ep_ff  <= eq_ff - prod_ff[W:0];
            eq_ff  <= ep_ff;
            emm_ff <= ea_ff;
            ea_ff  <= rem_w;
         end
         mau_pkg::OP_SET_INV: inv_ff <= qnorm[W-1:0];
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      case (ctl.op)
         mau_pkg::OP_SET_SIMPLE: begin
            res_ff   <= simple_res;
            valid_ff <= simple_valid;
            equal_ff <= (act_ff == mau_pkg::ACT_CMP) && (a_ff == b_ff);
         end
         mau_pkg::OP_SET_RES_REM, mau_pkg::OP_SET_RES_RAW, mau_pkg::OP_SET_RES_P,
         mau_pkg::OP_SET_INV_RES, mau_pkg::OP_SET_FAIL: begin
            valid_ff <= (ctl.op != mau_pkg::OP_SET_FAIL);
            equal_ff <= 1'b0;
            case (ctl.op)
               mau_pkg::OP_SET_RES_REM: res_ff <= rem_w;
               mau_pkg::OP_SET_RES_RAW:
                  res_ff <= (raw_ff[63] && rem_w != '0) ? m_ff - rem_w : rem_w;
               mau_pkg::OP_SET_RES_P: res_ff <= p_ff;
               mau_pkg::OP_SET_INV_RES: res_ff <= qnorm[W-1:0];
               default: res_ff <= '0;
            endcase
         end
         default: ;
      endcase
   end

   assign sts.action   = act_ff;
   assign sts.div_busy = busy_ff;
   assign sts.e_zero   = (e_ff == '0);
   assign sts.e_lsb    = e_ff[0];
   assign sts.ea_zero  = (ea_ff == '0);
   assign sts.emm_one  = (emm_ff == W'(1));

   assign rsp_data.result    = 31'(res_ff);
   assign rsp_data.valid_res = valid_ff;
   assign rsp_data.equal     = equal_ff;

endmodule
`default_nettype wire

/* hdl/mau_ctrl.sv */
// Sequencer for the modular arithmetic unit; drives datapath commands.
// Depends on mau_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mau_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   input  wire mau_pkg::sts_type sts,
   output mau_pkg::ctl_type      ctl
);
   mau_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mau_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      ctl.op    = mau_pkg::OP_NONE;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         mau_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctl.op   = mau_pkg::OP_LOAD;
               state_in = mau_pkg::ST_RED_A;
            end
         end
         mau_pkg::ST_RED_A: begin
            ctl.op   = mau_pkg::OP_DIV_A;
            state_in = mau_pkg::ST_WAIT_A;
         end
         mau_pkg::ST_WAIT_A: if (!sts.div_busy) begin
            ctl.op   = mau_pkg::OP_SET_A;
            state_in = mau_pkg::ST_RED_B;
         end
         mau_pkg::ST_RED_B: begin
            ctl.op   = mau_pkg::OP_DIV_B;
            state_in = mau_pkg::ST_WAIT_B;
         end
         mau_pkg::ST_WAIT_B: if (!sts.div_busy) begin
            ctl.op   = mau_pkg::OP_SET_B;
            state_in = mau_pkg::ST_DISPATCH;
         end
         mau_pkg::ST_DISPATCH: begin
            unique case (sts.action)
               mau_pkg::ACT_MUL: begin
                  ctl.op   = mau_pkg::OP_MUL_AB;
                  state_in = mau_pkg::ST_DIV_MUL;
               end
               mau_pkg::ACT_DIV, mau_pkg::ACT_INV: begin
                  ctl.op   = mau_pkg::OP_EUC_INIT;
                  state_in = mau_pkg::ST_EUC_CHECK;
               end
               mau_pkg::ACT_POW: begin
                  ctl.op   = mau_pkg::OP_POW_INIT;
                  state_in = mau_pkg::ST_POW_CHECK;
               end
               mau_pkg::ACT_RED: begin
                  ctl.op   = mau_pkg::OP_DIV_RAW;
                  state_in = mau_pkg::ST_WAIT_RAW;
               end
               default: begin
                  ctl.op   = mau_pkg::OP_SET_SIMPLE;
                  state_in = mau_pkg::ST_OUT;
               end
            endcase
         end
         mau_pkg::ST_DIV_MUL: begin
            ctl.op   = mau_pkg::OP_DIV_PROD;
            state_in = mau_pkg::ST_WAIT_MUL;
         end
         mau_pkg::ST_WAIT_MUL: if (!sts.div_busy) begin
            ctl.op   = mau_pkg::OP_SET_RES_REM;
            state_in = mau_pkg::ST_OUT;
         end
         mau_pkg::ST_WAIT_RAW: if (!sts.div_busy) begin
            ctl.op   = mau_pkg::OP_SET_RES_RAW;
            state_in = mau_pkg::ST_OUT;
         end
         mau_pkg::ST_POW_CHECK: begin
            if (sts.e_zero) begin
               ctl.op   = mau_pkg::OP_SET_RES_P;
               state_in = mau_pkg::ST_OUT;
            end else if (sts.e_lsb) begin
               ctl.op   = mau_pkg::OP_MUL_PB;
               state_in = mau_pkg::ST_POW_DIV_PB;
            end else begin
               ctl.op   = mau_pkg::OP_MUL_BB;
               state_in = mau_pkg::ST_POW_DIV_BB;
            end
         end
         mau_pkg::ST_POW_DIV_PB: begin
            ctl.op   = mau_pkg::OP_DIV_PROD;
            state_in = mau_pkg::ST_WAIT_PB;
         end
         mau_pkg::ST_WAIT_PB: if (!sts.div_busy) begin
            ctl.op   = mau_pkg::OP_SET_P;
            state_in = mau_pkg::ST_POW_MUL_BB;
         end
         mau_pkg::ST_POW_MUL_BB: begin
            ctl.op   = mau_pkg::OP_MUL_BB;
            state_in = mau_pkg::ST_POW_DIV_BB;
         end
         mau_pkg::ST_POW_DIV_BB: begin
            ctl.op   = mau_pkg::OP_DIV_PROD;
            state_in = mau_pkg::ST_WAIT_BB;
         end
         mau_pkg::ST_WAIT_BB: if (!sts.div_busy) begin
            ctl.op   = mau_pkg::OP_SET_BASE;
            state_in = mau_pkg::ST_POW_CHECK;
         end
         mau_pkg::ST_EUC_CHECK: begin
            if (sts.ea_zero) begin
               state_in = mau_pkg::ST_EUC_END;
            end else begin
               ctl.op   = mau_pkg::OP_DIV_EUC;
               state_in = mau_pkg::ST_EUC_WAIT;
            end
         end
         mau_pkg::ST_EUC_WAIT: if (!sts.div_busy) begin
            ctl.op   = mau_pkg::OP_MUL_TP;
            state_in = mau_pkg::ST_EUC_STEP;
         end
         mau_pkg::ST_EUC_STEP: begin
            ctl.op   = mau_pkg::OP_EUC_STEP;
            state_in = mau_pkg::ST_EUC_CHECK;
         end
         mau_pkg::ST_EUC_END: begin
            if (!sts.emm_one) begin
               ctl.op   = mau_pkg::OP_SET_FAIL;
               state_in = mau_pkg::ST_OUT;
            end else if (sts.action == mau_pkg::ACT_INV) begin
               ctl.op   = mau_pkg::OP_SET_INV_RES;
               state_in = mau_pkg::ST_OUT;
            end else begin
               ctl.op   = mau_pkg::OP_SET_INV;
               state_in = mau_pkg::ST_INV_MUL;
            end
         end
         mau_pkg::ST_INV_MUL: begin
            ctl.op   = mau_pkg::OP_MUL_IA;
            state_in = mau_pkg::ST_DIV_MUL;
         end
         mau_pkg::ST_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = mau_pkg::ST_IDLE;
            end
         end
         default: state_in = mau_pkg::ST_IDLE;
      endcase
   end

endmodule
`default_nettype wire

/* hdl/modular_arithmetic_unit.sv */
// Top level of the modular arithmetic unit: sequencer plus datapath.
// Depends on mau_pkg, mau_ctrl and mau_datapath.
//
// Usage: a request on req_* selects one operation (add, sub, mul, div, neg,
// pow, inverse, reduce, compare) on residues modulo the modulus register,
// written through csr_* (always ready; write only while the unit is idle).
// Each request gives exactly one response on rsp_*.
// One request is processed at a time; req_ready is high only when idle.
// All residues go through a bit-serial divider, one quotient bit per cycle:
// both operands are reduced first, and each modular multiply is a product
// followed by a divider pass. Add/sub/neg/compare need only the operand
// reduction, reduce adds one pass over the 64-bit raw value, pow one or two
// multiplies per exponent bit, and inverse/div one divider pass and one
// multiply per Euclid step.
// Reset restores the modulus to 998244353 and returns the sequencer to idle.
// A finished response is held on rsp_data until rsp_ready; no new request
// is taken while it waits.
`timescale 1ns / 1ps
`default_nettype none
module modular_arithmetic_unit #(
   parameter int MOD_WIDTH = 31
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire mau_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output mau_pkg::rsp_type      rsp_data,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [30:0]      csr_data
);
   mau_pkg::ctl_type ctl;
   mau_pkg::sts_type sts;

   assign csr_ready = 1'b1;

   mau_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .ctl       (ctl)
   );

   mau_datapath #(
      .MOD_WIDTH (MOD_WIDTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .req_data  (req_data),
      .ctl       (ctl),
      .sts       (sts),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire
